// File: rtl/tagged_block_allocator_assert.svh
// Assertion macros used by the allocator checker.
`ifndef TAGGED_BLOCK_ALLOCATOR_ASSERT_SVH
`define TAGGED_BLOCK_ALLOCATOR_ASSERT_SVH

// Clocked assertion, switched off while reset is asserted.
`define TBA_ASSERT(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error(msg);

// Clocked assertion that also holds through reset.
`define TBA_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

// File: rtl/tba_pkg.sv
// Types, constants and codes of the tagged block allocator.
package tba_pkg;

    localparam int NUM_BLOCKS    = 256;
    localparam int LOGICAL_SPACE = 1024;

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int TAG_W  = $clog2(LOGICAL_SPACE);
    localparam int NEXT_W = $clog2(LOGICAL_SPACE + 1);

    localparam int KIND_W   = 2;
    localparam int AMOUNT_W = 9;
    localparam int LADDR_W  = 10;
    localparam int STATUS_W = 2;
    localparam int BASE_W   = 10;
    localparam int COUNT_W  = 9;
    localparam int POOL_W   = 9;

    localparam int S_TDATA_W = ((AMOUNT_W + LADDR_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((BASE_W + COUNT_W + 7) / 8) * 8;

    localparam logic [POOL_W-1:0] POOL_RESET = POOL_W'(256);

    localparam logic [KIND_W-1:0] KIND_ALLOC = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_INIT  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_NO_SPACE  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_EXHAUSTED = 2'd3;

    // one entry of the block table
    typedef struct packed {
        logic             used;
        logic [TAG_W-1:0] owner;
    } cell_t;

    // controls broadcast to every cell of the chain
    typedef struct packed {
        logic shift;
        logic clear;
    } chain_ctrl_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_COUNT,
        S_CHECK,
        S_CLAIM,
        S_FREE_RD,
        S_FREE_CHK,
        S_FREE,
        S_RESP
    } state_t;

endpackage

// File: rtl/tba_ram.sv
// Generic single-port RAM with registered read.
module tba_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk) begin
        if (we) begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/tba_cell.sv
// One block table entry; shifts towards the head of the chain when enabled.
module tba_cell import tba_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  chain_ctrl_t ctrl,
    input  cell_t       d_in,
    output cell_t       d_out
);

    logic             used_reg;
    logic [TAG_W-1:0] owner_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg <= 1'b0;
        end else if (ctrl.clear) begin
            used_reg <= 1'b0;
        end else if (ctrl.shift) begin
            used_reg <= d_in.used;
        end
    end

    // tag only matters while the entry is used
    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            owner_reg <= d_in.owner;
        end
    end

    assign d_out = '{used: used_reg, owner: owner_reg};

endmodule

// File: rtl/tba_ctrl.sv
// Sequencer: request decode, table passes, valid-bit RAM access and result register.
module tba_ctrl import tba_pkg::*; (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [POOL_W-1:0]   cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [KIND_W-1:0]   in_kind,
    input  logic [AMOUNT_W-1:0] in_amount,
    input  logic [LADDR_W-1:0]  in_laddr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [STATUS_W-1:0] out_status,
    output logic [BASE_W-1:0]   out_base,
    output logic [COUNT_W-1:0]  out_count,
    output chain_ctrl_t         chain_ctrl,
    input  cell_t               head,
    output cell_t               tail,
    output logic                ram_we,
    output logic [TAG_W-1:0]    ram_addr,
    output logic [0:0]          ram_wdata,
    input  logic [0:0]          ram_rdata
);

    state_t state_reg, state_next;

    logic [POOL_W-1:0]   pool_reg,       pool_next;
    logic [AMOUNT_W-1:0] amount_reg,     amount_next;
    logic [LADDR_W-1:0]  laddr_reg,      laddr_next;
    logic [NEXT_W-1:0]   next_addr_reg,  next_addr_next;
    logic [IDX_W-1:0]    scan_reg,       scan_next;
    logic [COUNT_W-1:0]  tally_reg,      tally_next;
    logic [TAG_W-1:0]    clr_reg,        clr_next;
    logic                clr_resp_reg,   clr_resp_next;
    logic [STATUS_W-1:0] res_status_reg, res_status_next;
    logic [BASE_W-1:0]   res_base_reg,   res_base_next;
    logic [COUNT_W-1:0]  res_count_reg,  res_count_next;
    logic                out_valid_reg,  out_valid_next;
    logic [STATUS_W-1:0] out_status_reg, out_status_next;
    logic [BASE_W-1:0]   out_base_reg,   out_base_next;
    logic [COUNT_W-1:0]  out_count_reg,  out_count_next;

    logic accept;
    logic last_scan;
    logic last_clear;
    logic head_in_pool;
    logic short_pool;
    logic exhausted;
    logic laddr_in_range;
    logic out_free;

    assign in_ready       = (state_reg == S_IDLE);
    assign accept         = in_valid && in_ready;
    assign cfg_ready      = 1'b1;
    assign last_scan      = (scan_reg == IDX_W'(NUM_BLOCKS - 1));
    assign last_clear     = (clr_reg == TAG_W'(LOGICAL_SPACE - 1));
    // scan index equals the block number, so this also clamps to the table size
    assign head_in_pool   = (32'(scan_reg) < 32'(pool_reg));
    assign short_pool     = (tally_reg < amount_reg);
    assign exhausted      = (32'(next_addr_reg) >= LOGICAL_SPACE) ||
                            (32'(next_addr_reg) + 32'(amount_reg) > LOGICAL_SPACE);
    assign laddr_in_range = (32'(laddr_reg) < LOGICAL_SPACE);
    assign out_free       = !out_valid_reg || out_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR: begin
                if (last_clear) begin
                    state_next = clr_resp_reg ? S_RESP : S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (in_kind)
                        KIND_ALLOC: state_next = S_COUNT;
                        KIND_FREE:  state_next = S_FREE_RD;
                        KIND_INIT:  state_next = S_CLEAR;
                        default:    state_next = S_RESP;
                    endcase
                end
            end
            S_COUNT: begin
                if (last_scan) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                state_next = (short_pool || exhausted) ? S_RESP : S_CLAIM;
            end
            S_CLAIM: begin
                if (last_scan) begin
                    state_next = S_RESP;
                end
            end
            S_FREE_RD: begin
                state_next = laddr_in_range ? S_FREE_CHK : S_RESP;
            end
            S_FREE_CHK: begin
                state_next = ram_rdata[0] ? S_FREE : S_RESP;
            end
            S_FREE: begin
                if (last_scan) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        pool_next       = cfg_valid ? cfg_data : pool_reg;
        amount_next     = amount_reg;
        laddr_next      = laddr_reg;
        next_addr_next  = next_addr_reg;
        scan_next       = scan_reg;
        tally_next      = tally_reg;
        clr_next        = clr_reg;
        clr_resp_next   = clr_resp_reg;
        res_status_next = res_status_reg;
        res_base_next   = res_base_reg;
        res_count_next  = res_count_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_base_next   = out_base_reg;
        out_count_next  = out_count_reg;
        chain_ctrl      = '{shift: 1'b0, clear: 1'b0};
        tail            = head;
        ram_we          = 1'b0;
        ram_addr        = TAG_W'(laddr_reg);
        ram_wdata       = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ram_we    = 1'b1;
                ram_addr  = clr_reg;
                ram_wdata = 1'b0;
                clr_next  = last_clear ? '0 : clr_reg + 1'b1;
            end
            S_IDLE: begin
                if (accept) begin
                    amount_next     = in_amount;
                    laddr_next      = in_laddr;
                    scan_next       = '0;
                    tally_next      = '0;
                    res_status_next = STATUS_OK;
                    res_base_next   = '0;
                    res_count_next  = '0;
                    if (in_kind == KIND_INIT) begin
                        chain_ctrl.clear = 1'b1;
                        next_addr_next   = '0;
                        clr_next         = '0;
                        clr_resp_next    = 1'b1;
                    end
                end
            end
            S_COUNT: begin
                chain_ctrl.shift = 1'b1;
                if (head_in_pool && !head.used && short_pool) begin
                    tally_next = tally_reg + 1'b1;
                end
                scan_next = last_scan ? '0 : scan_reg + 1'b1;
            end
            S_CHECK: begin
                tally_next = '0;
                if (short_pool) begin
                    res_status_next = STATUS_NO_SPACE;
                end else if (exhausted) begin
                    res_status_next = STATUS_EXHAUSTED;
                end else begin
                    ram_we    = 1'b1;
                    ram_addr  = TAG_W'(next_addr_reg);
                    ram_wdata = 1'b1;
                end
            end
            S_CLAIM: begin
                chain_ctrl.shift = 1'b1;
                if (head_in_pool && !head.used && short_pool) begin
                    tail.used  = 1'b1;
                    tail.owner = TAG_W'(next_addr_reg);
                    tally_next = tally_reg + 1'b1;
                end
                scan_next = last_scan ? '0 : scan_reg + 1'b1;
                if (last_scan) begin
                    res_base_next  = BASE_W'(next_addr_reg);
                    res_count_next = COUNT_W'(amount_reg);
                    next_addr_next = next_addr_reg + NEXT_W'(amount_reg);
                end
            end
            S_FREE_RD: begin
                if (!laddr_in_range) begin
                    res_status_next = STATUS_NOT_FOUND;
                end
            end
            S_FREE_CHK: begin
                if (!ram_rdata[0]) begin
                    res_status_next = STATUS_NOT_FOUND;
                end
            end
            S_FREE: begin
                chain_ctrl.shift = 1'b1;
                if (head.used && head.owner == TAG_W'(laddr_reg)) begin
                    tail.used  = 1'b0;
                    tail.owner = '0;
                    if (tally_reg != '1) begin
                        tally_next = tally_reg + 1'b1;
                    end
                end
                scan_next = last_scan ? '0 : scan_reg + 1'b1;
                if (last_scan) begin
                    ram_we         = 1'b1;
                    ram_wdata      = 1'b0;
                    res_count_next = tally_next;
                end
            end
            S_RESP: begin
                if (out_free) begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_base_next   = res_base_reg;
                    out_count_next  = res_count_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_CLEAR;
            pool_reg      <= POOL_RESET;
            next_addr_reg <= '0;
            clr_reg       <= '0;
            clr_resp_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            pool_reg      <= pool_next;
            next_addr_reg <= next_addr_next;
            clr_reg       <= clr_next;
            clr_resp_reg  <= clr_resp_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        amount_reg     <= amount_next;
        laddr_reg      <= laddr_next;
        scan_reg       <= scan_next;
        tally_reg      <= tally_next;
        res_status_reg <= res_status_next;
        res_base_reg   <= res_base_next;
        res_count_reg  <= res_count_next;
        out_status_reg <= out_status_next;
        out_base_reg   <= out_base_next;
        out_count_reg  <= out_count_next;
    end

    assign out_valid  = out_valid_reg;
    assign out_status = out_status_reg;
    assign out_base   = out_base_reg;
    assign out_count  = out_count_reg;

endmodule

// File: rtl/tagged_block_allocator.sv
// Tagged block allocator: the sequencer, the rotating chain of table cells and the
// valid-bit RAM.
//
// Requests enter on the s_ channel (kind on s_tuser, amount and logical address on
// s_tdata); one result per request leaves on the m_ channel (status on m_tuser, base
// address and block count on m_tdata). pool_size is written on the cfg_ channel,
// which is always ready; write it only while no request is in flight.
// One request is worked at a time. The block table is a ring of NUM_BLOCKS cells
// that rotates one place per cycle past the sequencer while a table pass runs.
// Allocate: a count pass, a check, then a claim pass; a refused request is
// answered after the check. Free: a RAM read and check of the valid bit, then one
// pass; an address out of range or not marked valid gets no pass. Initialize: one
// write per logical address. Other kinds are answered without a table pass.
// s_tready is high again from the cycle in which the result appears.
// After reset the valid-bit RAM is swept, one write per logical address, with s_tready low.
// Results sit in an output register; while the receiver stalls, the next request
// is still taken and worked, and it waits for that register to empty.
module tagged_block_allocator import tba_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [POOL_W-1:0]    cfg_data,     // pool_size
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,      // amount, logical_addr, zero pad
    input  logic [KIND_W-1:0]    s_tuser,      // kind
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,      // base_addr, block_count, zero pad
    output logic [STATUS_W-1:0]  m_tuser       // status
);

    chain_ctrl_t        chain_ctrl;
    cell_t              chain_bus [NUM_BLOCKS+1];
    logic               ram_we;
    logic [TAG_W-1:0]   ram_addr;
    logic [0:0]         ram_wdata;
    logic [0:0]         ram_rdata;
    logic [BASE_W-1:0]  out_base;
    logic [COUNT_W-1:0] out_count;

    tba_ctrl u_ctrl (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_amount  (s_tdata[AMOUNT_W-1:0]),
        .in_laddr   (s_tdata[AMOUNT_W +: LADDR_W]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_status (m_tuser),
        .out_base   (out_base),
        .out_count  (out_count),
        .chain_ctrl (chain_ctrl),
        .head       (chain_bus[0]),
        .tail       (chain_bus[NUM_BLOCKS]),
        .ram_we     (ram_we),
        .ram_addr   (ram_addr),
        .ram_wdata  (ram_wdata),
        .ram_rdata  (ram_rdata)
    );

    // cell k takes from cell k+1; the sequencer writes back into the tail
    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        tba_cell u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (chain_ctrl),
            .d_in    (chain_bus[k+1]),
            .d_out   (chain_bus[k])
        );
    end

    tba_ram #(
        .WIDTH (1),
        .DEPTH (LOGICAL_SPACE)
    ) u_valid_ram (
        .clk   (aclk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    assign m_tdata = M_TDATA_W'({out_count, out_base});

endmodule

// File: rtl/tba_checker.sv
// Port-level checks of the tagged block allocator, bound to the top level.
`include "tagged_block_allocator_assert.svh"

module tba_checker import tba_pkg::*; (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_tvalid,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    logic in_take;
    logic out_stall;
    logic out_failed;

    assign in_take    = s_tvalid && s_tready;
    assign out_stall  = m_tvalid && !m_tready;
    assign out_failed = m_tvalid && (m_tuser != STATUS_OK);

    `TBA_ASSERT(a_result_held, aclk, aresetn, out_stall |=> m_tvalid, "result dropped")

    `TBA_ASSERT(a_one_in_flight, aclk, aresetn, in_take |=> !s_tready, "request taken while busy")

    `TBA_ASSERT(a_error_zero, aclk, aresetn, out_failed |-> m_tdata == '0, "refusal carries data")

    `TBA_ASSERT(a_sweep_after_reset, aclk, aresetn, $rose(aresetn) |-> !s_tready, "ready in sweep")

    `TBA_ASSERT_ALWAYS(a_reset_empties, aclk, !aresetn |=> !m_tvalid, "result survives reset")

endmodule

bind tagged_block_allocator tba_checker u_tba_checker (.*);
